[src/pts_pkg.sv]
package pts_pkg;

  // Ready queue size and derived widths
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Command codes
  typedef enum logic [1:0] {
    OP_CREATE   = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_TICK     = 2'd2,
    OP_NOP      = 2'd3
  } opcode_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // One queued task
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } entry_t;

  // Command word
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] task_id;
    logic [7:0] priority_req;
  } req_t;

  // Result word
  typedef struct packed {
    logic       run_valid;
    logic [7:0] run_task;
    logic [7:0] run_priority;
    logic       switched;
    logic [1:0] status;
    logic [4:0] ready_count;
  } rsp_t;

  // Per-cycle command broadcast to every queue cell
  typedef struct packed {
    logic   ins;   // insert item in priority order
    logic   pop;   // drop the head, shift toward the head
    entry_t item;  // task to insert
  } cell_ctrl_t;

endpackage

[src/priority_task_scheduler.sv]
// Channel   Ports               Handshake
// command   start, busy, req    word taken at an edge with start high and busy low
// result    done, rsp           word valid for the single cycle done is high
//
// One command per cycle: the result word is registered and appears in the cycle
// after the command is taken, and busy stays low, since all queue cells shift or
// insert together. Synchronous active-high rst empties the queue and the running
// slot. The result side has no back-pressure; a result not sampled while
// done is high is lost.
module priority_task_scheduler
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic             slot_valid;
  logic             slot_valid_next;
  entry_t           slot;
  entry_t           slot_next;
  rsp_t             rsp_next;
  cell_ctrl_t       ctrl;
  logic             sw;
  status_t          status;
  logic             accept;

  logic   [QUEUE_DEPTH-1:0] occ;
  logic   [QUEUE_DEPTH-1:0] stays;
  entry_t [QUEUE_DEPTH-1:0] cells;
  entry_t                   head;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign head   = cells[0];

  // Occupancy of each cell from the fill count
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      occ[i] = (CNT_W'(i) < fill);
    end
  end

  // Command decode
  always_comb begin
    fill_next       = fill;
    slot_valid_next = slot_valid;
    slot_next       = slot;
    ctrl.ins        = 1'b0;
    ctrl.pop        = 1'b0;
    ctrl.item.id    = req.task_id;
    ctrl.item.prio  = req.priority_req;
    sw              = 1'b0;
    status          = ST_OK;
    if (accept) begin
      unique case (opcode_t'(req.opcode))
        OP_CREATE: begin
          if (fill >= CNT_W'(QUEUE_DEPTH)) begin
            status = ST_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            fill_next = fill + CNT_W'(1);
          end
        end
        OP_DISPATCH: begin
          if (!slot_valid) begin
            if (fill == '0) begin
              status = ST_EMPTY;
            end else begin
              slot_next       = head;
              slot_valid_next = 1'b1;
              ctrl.pop        = 1'b1;
              fill_next       = fill - CNT_W'(1);
              sw              = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (fill == '0) begin
            if (!slot_valid) status = ST_EMPTY;
          end else if (slot_valid && (head.prio >= slot.prio)) begin
            // preempt: head runs, old task re-enters ahead of its peers
            slot_next = head;
            ctrl.pop  = 1'b1;
            ctrl.ins  = 1'b1;
            ctrl.item = slot;
            sw        = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Queue cells, head at index 0
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_s;
    logic   occ_r;
    if (g == 0) begin : g_first
      assign left_e = ctrl.item;
      assign left_s = 1'b1;
    end else begin : g_mid
      assign left_e = cells[g-1];
      assign left_s = stays[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = '0;
      assign occ_r   = 1'b0;
    end else begin : g_inner
      assign right_e = cells[g+1];
      assign occ_r   = occ[g+1];
    end
    pts_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ_self   (occ[g]),
      .occ_right  (occ_r),
      .left_entry (left_e),
      .right_entry(right_e),
      .left_stays (left_s),
      .stays      (stays[g]),
      .entry      (cells[g])
    );
  end

  // Result word from the updated state
  always_comb begin
    rsp_next.run_valid    = slot_valid_next;
    rsp_next.run_task     = slot_valid_next ? slot_next.id : 8'd0;
    rsp_next.run_priority = slot_valid_next ? slot_next.prio : 8'd0;
    rsp_next.switched     = sw;
    rsp_next.status       = status;
    rsp_next.ready_count  = 5'(fill_next);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      slot_valid <= 1'b0;
      slot       <= '0;
      done       <= 1'b0;
    end else begin
      fill       <= fill_next;
      slot_valid <= slot_valid_next;
      slot       <= slot_next;
      done       <= accept;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) rsp <= rsp_next;
  end

endmodule

[src/pts_cell.sv]
module pts_cell
  import pts_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ_self,    // this cell holds a queued task
  input  logic       occ_right,   // the next cell holds a queued task
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  input  logic       left_stays,  // everything toward the head stays ahead of the new task
  output logic       stays,
  output entry_t     entry
);

  entry_t entry_next;

  // Keep-in-place decision against the view this cell sees after any pop
  always_comb begin
    if (ctrl.pop) begin
      stays = occ_right && (right_entry.prio > ctrl.item.prio);
    end else begin
      stays = occ_self && (entry.prio > ctrl.item.prio);
    end
  end

  // Next contents: shift, insert or hold
  always_comb begin
    entry_next = entry;
    if (ctrl.pop && ctrl.ins) begin
      // pop then insert: a cell takes its right neighbor, the new task, or keeps its own
      if (stays) begin
        entry_next = right_entry;
      end else if (left_stays) begin
        entry_next = ctrl.item;
      end else begin
        entry_next = entry;
      end
    end else if (ctrl.ins) begin
      if (stays) begin
        entry_next = entry;
      end else if (left_stays) begin
        entry_next = ctrl.item;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
